// ----- sv/stag_pkg.sv -----
`default_nettype none

package stag_pkg;

  // Default parameter values of the top level
  localparam int MAX_DIMS_DEF  = 4;
  localparam int SIZE_BITS_DEF = 16;
  localparam int ADDR_BITS_DEF = 40;

  // Fixed field widths
  localparam int COORD_BITS    = 16;
  localparam int LANE_BITS     = 16;
  localparam int IDX_BITS      = 32;
  localparam int STRIDE_BITS   = 32;
  localparam int BASE_BITS     = 40;
  localparam int EBYTES_BITS   = 4;
  localparam int DCOUNT_BITS   = 3;
  localparam int NUM_STRIDES   = 3;
  localparam int NUM_COORDS    = 4;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_BYTES = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_COUNT     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_SIZES     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_DIM1   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_DIM2   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_DIM3   = 3'd6;

  // Operation codes carried in the input tuser
  localparam logic OP_SEEK    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic                  start;
    logic [IDX_BITS-1:0]   dividend;
    logic [COORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [IDX_BITS-1:0]   quotient;
    logic [COORD_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/stag_div.sv -----
`default_nettype none

// Radix-2 restoring divider: one quotient bit per cycle.
module stag_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stag_pkg::div_req_t req_i,
  output stag_pkg::div_rsp_t      rsp_o
);
  import stag_pkg::*;

  localparam int CNT_BITS = $clog2(IDX_BITS);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [IDX_BITS-1:0]   quo_q;
  logic [COORD_BITS-1:0] rem_q;
  logic [COORD_BITS-1:0] dvs_q;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[IDX_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(IDX_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      quo_q <= {quo_q[IDX_BITS-2:0], fits};
      rem_q <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ----- sv/strided_tensor_address_generator_top.sv -----
// Strided tensor address generator for up to MAX_DIMS dimensions. An input
// transaction carries the operation in s_axis_tuser (0 seek, 1 advance) and
// the linear element index in s_axis_tdata; every input transaction yields
// exactly one output transaction holding the byte address, the four
// coordinates and the wrapped and index_error flags. One item is in work at a
// time and s_axis_tready is low while it runs; a finished result waits in the
// output register while the next item is taken. Address assembly runs on a
// shared 33x16 multiplier, one dimension at a time: an advance loads coord_0,
// adds one stride term per outer dimension, scales by the element size and
// adds the base. A seek first forms the size products and checks the index;
// a seek in range then divides one dimension at a time in the bit-serial
// divider, the outermost dimension taking what is left. While the output
// register holds a result that is not taken, a new result waits in the last
// step and the input stays stalled. Configuration registers are written
// through cfg_we_i; the user must write them only while the block is idle,
// which the block itself does not enforce.
`default_nettype none

module strided_tensor_address_generator_top #(
  parameter int MAX_DIMS  = stag_pkg::MAX_DIMS_DEF,
  parameter int SIZE_BITS = stag_pkg::SIZE_BITS_DEF,
  parameter int ADDR_BITS = stag_pkg::ADDR_BITS_DEF,
  localparam int OUT_RAW  = ADDR_BITS + stag_pkg::NUM_COORDS * stag_pkg::COORD_BITS + 2,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [stag_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [stag_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output      logic                                 s_axis_tready,
  input  wire logic [stag_pkg::IDX_BITS-1:0]        s_axis_tdata,  // element_index
  input  wire logic                                 s_axis_tuser,  // operation
  // output stream
  output      logic                                 m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // address, coord_0, coord_1, coord_2, coord_3, wrapped, index_error, zero pad
  output      logic [OUT_W-1:0]                     m_axis_tdata
);
  import stag_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIMS + 1);
  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam int MUL_A_W = IDX_BITS + 1;
  localparam int MUL_W   = MUL_A_W + COORD_BITS;
  localparam int SCL_W   = ADDR_BITS + EBYTES_BITS;
  localparam logic [MUL_A_W-1:0] PROD_SAT = {1'b1, {IDX_BITS{1'b0}}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PROD  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_SPLIT = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_AINIT = 4'd5;
  localparam logic [3:0] ST_MAC   = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_SUM   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // configuration registers
  logic [BASE_BITS-1:0]   base_q;
  logic [EBYTES_BITS-1:0] ebytes_q;
  logic [DCOUNT_BITS-1:0] dcount_q;
  logic [SIZE_BITS-1:0]   sizes_q  [MAX_DIMS];
  logic [STRIDE_BITS-1:0] stride_q [NUM_STRIDES];

  // control and state
  logic [3:0]             state_q, state_d;
  logic [CNT_W-1:0]       dim_q;
  logic [COORD_BITS-1:0]  coord_q  [MAX_DIMS];
  logic                   m_valid_q;

  // datapath
  logic [IDX_BITS-1:0]    idx_q;
  logic [IDX_BITS-1:0]    rest_q;
  logic [MUL_A_W-1:0]     prod_q;
  logic [MUL_W-1:0]       mul_q;
  logic [ADDR_BITS-1:0]   acc_q;
  logic                   wrap_q;
  logic                   err_q;
  logic [OUT_W-1:0]       out_data_q;

  logic                   s_fire;
  logic                   out_load;
  logic [CNT_W-1:0]       n_used;
  logic [DIM_W-1:0]       dim_idx;
  logic                   dim_last;
  logic [SIZE_BITS-1:0]   size_sel;
  logic [STRIDE_BITS-1:0] stride_sel;
  logic [MUL_A_W-1:0]     mul_a;
  logic [COORD_BITS-1:0]  mul_b;
  logic [MUL_W-1:0]       mul_res;
  logic [MUL_A_W-1:0]     prod_sat;
  logic [SCL_W-1:0]       scaled;
  logic [COORD_BITS-1:0]  adv_coord [MAX_DIMS];
  logic                   adv_wrap;
  logic [COORD_BITS-1:0]  coord_out [NUM_COORDS];
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

  // dimensions in use: zero acts as one, clamp to MAX_DIMS
  always_comb begin
    if (dcount_q == '0) begin
      n_used = CNT_ONE;
    end else if (int'(dcount_q) > MAX_DIMS) begin
      n_used = CNT_W'(MAX_DIMS);
    end else begin
      n_used = CNT_W'(dcount_q);
    end
  end

  assign dim_idx  = dim_q[DIM_W-1:0];
  assign dim_last = (dim_q + CNT_ONE) == n_used;
  assign size_sel = sizes_q[dim_idx];

  always_comb begin
    case (dim_q)
      CNT_W'(1): stride_sel = stride_q[0];
      CNT_W'(2): stride_sel = stride_q[1];
      CNT_W'(3): stride_sel = stride_q[2];
      default:   stride_sel = STRIDE_BITS'(1);
    endcase
  end

  // shared multiplier: size products during a seek, stride terms otherwise
  always_comb begin
    if (state_q == ST_PROD) begin
      mul_a = prod_q;
      mul_b = COORD_BITS'(size_sel);
    end else begin
      mul_a = {1'b0, stride_sel};
      mul_b = coord_q[dim_idx];
    end
  end

  assign mul_res  = MUL_W'(mul_a) * MUL_W'(mul_b);
  // hold the element count saturated just above the index range
  assign prod_sat = (|mul_res[MUL_W-1:IDX_BITS]) ? PROD_SAT : mul_res[MUL_A_W-1:0];
  assign scaled   = SCL_W'(acc_q) * SCL_W'(ebytes_q);

  // odometer step, innermost dimension first
  always_comb begin
    logic                carry;
    logic [COORD_BITS:0] nxt;
    carry = 1'b1;
    nxt   = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      adv_coord[d] = coord_q[d];
      if (carry && (CNT_W'(d) < n_used)) begin
        nxt = {1'b0, coord_q[d]} + 1'b1;
        if (nxt >= (COORD_BITS + 1)'(sizes_q[d])) begin
          adv_coord[d] = '0;
        end else begin
          adv_coord[d] = nxt[COORD_BITS-1:0];
          carry        = 1'b0;
        end
      end
    end
    adv_wrap = carry;
  end

  assign div_req.start    = (state_q == ST_SPLIT) && !dim_last && (size_sel != '0);
  assign div_req.dividend = rest_q;
  assign div_req.divisor  = COORD_BITS'(size_sel);

  stag_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = (s_axis_tuser == OP_ADVANCE) ? ST_AINIT : ST_PROD;
        end
      end
      ST_PROD:  if (dim_last) state_d = ST_CHECK;
      ST_CHECK: state_d = ({1'b0, idx_q} >= prod_q) ? ST_AINIT : ST_SPLIT;
      ST_SPLIT: state_d = (dim_last || size_sel == '0) ? ST_AINIT : ST_DIV;
      ST_DIV:   if (div_rsp.done) state_d = ST_SPLIT;
      ST_AINIT: state_d = ST_MAC;
      ST_MAC:   state_d = (dim_q < n_used) ? ST_ACC : ST_SCALE;
      ST_ACC:   state_d = ST_MAC;
      ST_SCALE: state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dim_q     <= '0;
      m_valid_q <= 1'b0;
      base_q    <= '0;
      ebytes_q  <= EBYTES_BITS'(1);
      dcount_q  <= DCOUNT_BITS'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
        sizes_q[d] <= SIZE_BITS'(1);
        coord_q[d] <= '0;
      end
      for (int s = 0; s < NUM_STRIDES; s++) begin
        stride_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          dim_q <= '0;
          if (s_fire && s_axis_tuser == OP_ADVANCE) begin
            coord_q <= adv_coord;
          end
        end
        ST_PROD:  dim_q <= dim_q + CNT_ONE;
        ST_CHECK: begin
          dim_q <= '0;
          if ({1'b0, idx_q} < prod_q) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
              coord_q[d] <= '0;
            end
          end
        end
        ST_SPLIT: begin
          // last dimension or a zero size takes what is left
          if (dim_last || size_sel == '0) begin
            coord_q[dim_idx] <= rest_q[COORD_BITS-1:0];
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            coord_q[dim_idx] <= div_rsp.remainder;
            dim_q            <= dim_q + CNT_ONE;
          end
        end
        ST_AINIT: dim_q <= CNT_ONE;
        ST_ACC:   dim_q <= dim_q + CNT_ONE;
        ST_MAC, ST_SCALE, ST_SUM, ST_OUT: begin
        end
        default: begin
        end
      endcase

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE_ADDRESS:  base_q   <= cfg_wdata_i[BASE_BITS-1:0];
          REG_ELEMENT_BYTES: ebytes_q <= cfg_wdata_i[EBYTES_BITS-1:0];
          REG_DIM_COUNT:     dcount_q <= cfg_wdata_i[DCOUNT_BITS-1:0];
          REG_DIM_SIZES: begin
            for (int d = 0; d < MAX_DIMS; d++) begin
              sizes_q[d] <= cfg_wdata_i[LANE_BITS*d +: SIZE_BITS];
            end
          end
          REG_STRIDE_DIM1:   stride_q[0] <= cfg_wdata_i[STRIDE_BITS-1:0];
          REG_STRIDE_DIM2:   stride_q[1] <= cfg_wdata_i[STRIDE_BITS-1:0];
          REG_STRIDE_DIM3:   stride_q[2] <= cfg_wdata_i[STRIDE_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          wrap_q <= (s_axis_tuser == OP_ADVANCE) ? adv_wrap : 1'b0;
          err_q  <= 1'b0;
          idx_q  <= s_axis_tdata;
          prod_q <= MUL_A_W'(1);
        end
      end
      ST_PROD: prod_q <= prod_sat;
      ST_CHECK: begin
        err_q  <= ({1'b0, idx_q} >= prod_q);
        rest_q <= idx_q;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          rest_q <= div_rsp.quotient;
        end
      end
      ST_AINIT: acc_q <= ADDR_BITS'(coord_q[0]);
      ST_MAC:   mul_q <= mul_res;
      ST_ACC:   acc_q <= acc_q + ADDR_BITS'(mul_q);
      ST_SCALE: acc_q <= scaled[ADDR_BITS-1:0];
      ST_SUM:   acc_q <= acc_q + ADDR_BITS'(base_q);
      ST_OUT: begin
        if (out_load) begin
          out_data_q <= OUT_W'({err_q, wrap_q, coord_out[3], coord_out[2],
                                coord_out[1], coord_out[0], acc_q});
        end
      end
      ST_SPLIT: begin
      end
      default: begin
      end
    endcase
  end

  // dimensions beyond MAX_DIMS report zero
  for (genvar k = 0; k < NUM_COORDS; k++) begin : g_coord_out
    if (k < MAX_DIMS) begin : g_used
      assign coord_out[k] = coord_q[k];
    end else begin : g_absent
      assign coord_out[k] = '0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/stag_checker.sv -----
`default_nettype none

module stag_checker #(
  parameter int ADDR_BITS = stag_pkg::ADDR_BITS_DEF,
  localparam int OUT_RAW  = ADDR_BITS + stag_pkg::NUM_COORDS * stag_pkg::COORD_BITS + 2,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);
  import stag_pkg::*;

  localparam int WRAP_BIT = ADDR_BITS + NUM_COORDS * COORD_BITS;
  localparam int ERR_BIT  = WRAP_BIT + 1;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before it was taken");

  // one item at a time: busy right after a transaction is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // an advance cannot fail and a seek cannot wrap
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[WRAP_BIT] && m_axis_tdata[ERR_BIT]))
    else $error("wrapped and index_error both set");

  // a full wrap leaves the innermost coordinate at zero
  a_wrap_coord0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[WRAP_BIT] |->
      m_axis_tdata[ADDR_BITS +: COORD_BITS] == '0)
    else $error("wrap reported with nonzero coord_0");

endmodule

bind strided_tensor_address_generator_top stag_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_stag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
